// ===== src/updq_pkg.sv =====
// Package for the per-port receive queue demultiplexer: sizes, codes and types.
// Used by updq_cam and udp_port_demux_queues; depends on nothing.
package updq_pkg;
    localparam int PortEntries = 64;
    localparam int QueueSlots  = 16;
    localparam int HandleBits  = 10;
    localparam int EntryW = $clog2(PortEntries);
    localparam int SlotW  = $clog2(QueueSlots);
    localparam int CountW = $clog2(QueueSlots + 1);
    localparam logic [12:0] MinFrame = 13'd42;

    typedef enum logic [1:0] {
        K_BIND    = 2'd0,
        K_UNBIND  = 2'd1,
        K_DELIVER = 2'd2,
        K_RECEIVE = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        ST_OK         = 3'd0,
        ST_TABLE_FULL = 3'd1,
        ST_UNBOUND    = 3'd2,
        ST_QUEUE_FULL = 3'd3,
        ST_TOO_SHORT  = 3'd4,
        ST_EMPTY      = 3'd5,
        ST_RELEASED   = 3'd6
    } t_status;

    // Lookup result from the port table.
    typedef struct packed {
        logic              hit;
        logic [EntryW-1:0] hit_idx;
        logic              free;
        logic [EntryW-1:0] free_idx;
    } t_lookup;

    // Table update request.
    typedef struct packed {
        logic              set;
        logic              clr;
        logic [EntryW-1:0] idx;
        logic [15:0]       port;
    } t_tbl_wr;
endpackage

// ===== src/udp_port_demux_queues.sv =====
// Top level of the per-port receive queue demultiplexer.
// Depends on updq_pkg and updq_cam.
//
// One word in on the slave stream is one operation: bind, unbind, deliver or
// receive for a destination port. The block compares the port against all 64
// table entries (registered), then reads the entry's queue pointers and the
// slot memory, both with synchronous reads, and writes them back. Bind,
// deliver and a receive that finds no packet present their one result word
// from the EXEC state; a receive that returns a packet first takes its slot
// data in RDSL. Unbind gives one released word per queued packet, read from
// the slot memory and waiting in DRN until each is taken, then a final ok
// word; tlast marks the final word of each operation. A single operation is
// in flight at a time; a result waits in the output register while the caller
// stalls. Once the final word has been taken the block returns from OUT to
// idle. There is no clearing pass after reset.
module udp_port_demux_queues (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [9:0] handle, [22:10] length, zero fill to 24 bits
    input  logic [23:0] s_axis_tdata,
    // [1:0] kind, [17:2] port
    input  logic [17:0] s_axis_tuser,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [9:0] out_handle, [22:10] out_length, zero fill to 24 bits
    output logic [23:0] m_axis_tdata,
    // [2:0] status
    output logic [2:0]  m_axis_tuser,
    output logic        m_axis_tlast
);
    import updq_pkg::*;

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CMP  = 7'b0000010,
        S_LOOK = 7'b0000100,
        S_EXEC = 7'b0001000,
        S_RDSL = 7'b0010000,
        S_DRN  = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    t_state r_state, n_state;

    logic [1:0]  r_kind;
    logic [15:0] r_port;
    logic [9:0]  r_hnd;
    logic [12:0] r_len;
    logic [EntryW-1:0] r_ent;

    // Queue pointer memory: head, tail, count per entry.
    localparam int QW = SlotW + SlotW + CountW;
    logic [QW-1:0] qmem [PortEntries];
    logic [QW-1:0] r_qrd;
    logic          q_we;
    logic [QW-1:0] q_wd;
    logic [SlotW-1:0]  q_head, q_tail;
    logic [CountW-1:0] q_cnt;

    // Slot memory: handle and length.
    localparam int SAW = EntryW + SlotW;
    logic [22:0]    smem [PortEntries * QueueSlots];
    logic [22:0]    r_srd;
    logic           s_we;
    logic [SAW-1:0] s_addr;

    t_lookup lk;
    t_tbl_wr tw;

    // Output register.
    logic        r_ov;
    logic [2:0]  r_ost;
    logic [9:0]  r_oh;
    logic [12:0] r_ol;
    logic        r_olast;

    updq_cam u_cam (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_port  (r_port),
        .i_wr    (tw),
        .o_lookup(lk)
    );

    assign {q_head, q_tail, q_cnt} = r_qrd;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ov;
    assign m_axis_tdata  = {1'b0, r_ol, r_oh};
    assign m_axis_tuser  = r_ost;
    assign m_axis_tlast  = r_olast;

    // Memories: synchronous read, one write port each.
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOOK) begin
            r_qrd <= qmem[lk.hit_idx];
        end else if (r_state == S_RDSL && t_kind'(r_kind) == K_UNBIND && q_cnt != '0) begin
            // Drain keeps the pointer copy local; the memory entry is reset on bind.
            r_qrd <= {SlotW'(q_head + 1'b1), q_tail, CountW'(q_cnt - 1'b1)};
        end
        if (q_we) begin
            qmem[r_ent] <= q_wd;
        end
        r_srd <= smem[s_addr];
        if (s_we) begin
            smem[s_addr] <= {r_len, r_hnd};
        end
    end

    // Slot address: tail on deliver, head otherwise; entry read in LOOK.
    assign s_addr = {r_ent, (r_kind == K_DELIVER) ? q_tail : q_head};

    logic              emit;
    logic [2:0]        e_st;
    logic [9:0]        e_h;
    logic [12:0]       e_l;
    logic              e_last;

    always_comb begin
        n_state = r_state;
        q_we = 1'b0;
        q_wd = r_qrd;
        s_we = 1'b0;
        tw   = '0;
        tw.idx  = lk.free_idx;
        tw.port = r_port;
        emit = 1'b0;
        e_st = ST_OK;
        e_h  = '0;
        e_l  = '0;
        e_last = 1'b1;
        case (r_state)
            S_IDLE: if (s_axis_tvalid) n_state = S_CMP;
            S_CMP:  n_state = S_LOOK;
            S_LOOK: n_state = S_EXEC;
            S_EXEC: begin
                n_state = S_OUT;
                emit = 1'b1;
                case (t_kind'(r_kind))
                    K_BIND: begin
                        if (!lk.hit) begin
                            if (lk.free) begin
                                tw.set = 1'b1;
                                q_we   = 1'b1;
                                q_wd   = '0;
                            end else begin
                                e_st = ST_TABLE_FULL;
                            end
                        end
                    end
                    K_UNBIND: begin
                        if (lk.hit) begin
                            emit = 1'b0;
                            n_state = S_RDSL;
                        end
                    end
                    K_DELIVER: begin
                        e_h = r_hnd;
                        if (r_len < MinFrame) begin
                            e_st = ST_TOO_SHORT;
                        end else if (!lk.hit) begin
                            e_st = ST_UNBOUND;
                        end else if (q_cnt >= CountW'(QueueSlots)) begin
                            e_st = ST_QUEUE_FULL;
                        end else begin
                            e_h  = '0;
                            s_we = 1'b1;
                            q_we = 1'b1;
                            q_wd = {q_head, SlotW'(q_tail + 1'b1), CountW'(q_cnt + 1'b1)};
                        end
                    end
                    default: begin
                        if (!lk.hit) begin
                            e_st = ST_UNBOUND;
                        end else if (q_cnt == '0) begin
                            e_st = ST_EMPTY;
                        end else begin
                            emit = 1'b0;
                            n_state = S_RDSL;
                        end
                    end
                endcase
            end
            S_RDSL: begin
                // Slot data for the head is now in r_srd.
                if (t_kind'(r_kind) == K_RECEIVE) begin
                    emit = 1'b1;
                    e_h = r_srd[9:0];
                    e_l = r_srd[22:10];
                    q_we = 1'b1;
                    q_wd = {SlotW'(q_head + 1'b1), q_tail, CountW'(q_cnt - 1'b1)};
                    n_state = S_OUT;
                end else if (q_cnt == '0) begin
                    emit = 1'b1;
                    tw.clr = 1'b1;
                    tw.idx = r_ent;
                    n_state = S_OUT;
                end else begin
                    emit = 1'b1;
                    e_st = ST_RELEASED;
                    e_h = r_srd[9:0];
                    e_last = 1'b0;
                    n_state = S_DRN;
                end
            end
            S_DRN: begin
                // Wait for the released word to go, then read the next slot.
                if (!r_ov) n_state = S_RDSL;
            end
            S_OUT: if (!r_ov) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (emit) begin
                r_ov <= 1'b1;
            end else if (m_axis_tready) begin
                r_ov <= 1'b0;
            end
        end
        if (emit) begin
            r_ost   <= e_st;
            r_oh    <= e_h;
            r_ol    <= e_l;
            r_olast <= e_last;
        end
        if (r_state == S_IDLE) begin
            r_kind <= s_axis_tuser[1:0];
            r_port <= s_axis_tuser[17:2];
            r_hnd  <= s_axis_tdata[9:0];
            r_len  <= s_axis_tdata[22:10];
        end
        if (r_state == S_LOOK) begin
            r_ent <= (t_kind'(r_kind) == K_BIND) ? lk.free_idx : lk.hit_idx;
        end
    end
endmodule

// ===== src/updq_cam.sv =====
// Port binding table: used bits and ports in flip-flops, registered priority search.
// Depends on updq_pkg.
module updq_cam (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [15:0]      i_port,
    input  updq_pkg::t_tbl_wr i_wr,
    output updq_pkg::t_lookup o_lookup
);
    import updq_pkg::*;

    logic [PortEntries-1:0] r_used;
    logic [15:0]            r_port [PortEntries];
    logic [PortEntries-1:0] r_match;
    t_lookup                n_lookup;

    // Compare stage registered, priority encode in the next cycle.
    always_ff @(posedge i_clk) begin
        for (int i = 0; i < PortEntries; i++) begin
            r_match[i] <= r_used[i] && (r_port[i] == i_port);
        end
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (i_wr.set) begin
            r_used[i_wr.idx] <= 1'b1;
        end else if (i_wr.clr) begin
            r_used[i_wr.idx] <= 1'b0;
        end
        if (i_wr.set) begin
            r_port[i_wr.idx] <= i_wr.port;
        end
    end

    always_comb begin
        n_lookup = '0;
        for (int i = PortEntries - 1; i >= 0; i--) begin
            if (r_match[i]) begin
                n_lookup.hit     = 1'b1;
                n_lookup.hit_idx = EntryW'(i);
            end
            if (!r_used[i]) begin
                n_lookup.free     = 1'b1;
                n_lookup.free_idx = EntryW'(i);
            end
        end
    end

    assign o_lookup = n_lookup;
endmodule

// ===== tb/sv/udp_port_demux_queues_tb.sv =====
// Testbench for udp_port_demux_queues: drives bind, unbind, deliver and receive
// operations and checks every result word against a predictor of the port table.
// Depends on updq_pkg and the block's RTL.
module udp_port_demux_queues_tb;
    import updq_pkg::*;

    // One expected result word.
    typedef struct {
        t_status     status;
        logic [9:0]  hnd;
        logic [12:0] len;
        logic        last;
    } t_result;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [17:0] s_axis_tuser;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [23:0] m_axis_tdata;
    logic [2:0]  m_axis_tuser;
    logic        m_axis_tlast;

    udp_port_demux_queues dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    // Predictor state: a shadow copy of the port table and its slot rings.
    logic        bound_used [PortEntries];
    logic [15:0] bound_port [PortEntries];
    int          ring_head  [PortEntries];
    int          ring_tail  [PortEntries];
    int          ring_count [PortEntries];
    logic [9:0]  ring_hnd   [PortEntries*QueueSlots];
    logic [12:0] ring_len   [PortEntries*QueueSlots];

    t_result pending_results[$];
    int      errors;
    int      words_sent;
    int      words_checked;
    int      idle_cycles;
    int      send_idle_pct;
    int      recv_stall_pct;
    bit      timed_out;

    localparam int WatchdogLimit = 5000;

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    function automatic int lookup_port(logic [15:0] port);
        for (int i = 0; i < PortEntries; i++) begin
            if (bound_used[i] && bound_port[i] == port) return i;
        end
        return -1;
    endfunction

    function automatic void push_result(t_status st, logic [9:0] h, logic [12:0] l,
                                        logic lst);
        t_result r;
        r.status = st;
        r.hnd    = h;
        r.len    = l;
        r.last   = lst;
        pending_results.push_back(r);
    endfunction

    // Works out the result words of one operation and updates the shadow table.
    function automatic void predict_op(t_kind kind, logic [15:0] port, logic [9:0] h,
                                       logic [12:0] l);
        int e;
        int s;
        e = lookup_port(port);
        case (kind)
            K_BIND: begin
                if (e < 0) begin
                    for (int i = 0; i < PortEntries; i++) begin
                        if (!bound_used[i]) begin
                            e = i;
                            break;
                        end
                    end
                    if (e < 0) begin
                        push_result(ST_TABLE_FULL, '0, '0, 1'b1);
                        return;
                    end
                    bound_used[e] = 1'b1;
                    bound_port[e] = port;
                    ring_head[e]  = 0;
                    ring_tail[e]  = 0;
                    ring_count[e] = 0;
                end
                push_result(ST_OK, '0, '0, 1'b1);
            end
            K_UNBIND: begin
                if (e >= 0) begin
                    // Drain the ring oldest first, one released word per packet.
                    while (ring_count[e] > 0) begin
                        s = e * QueueSlots + ring_head[e];
                        push_result(ST_RELEASED, ring_hnd[s], '0, 1'b0);
                        ring_head[e] = (ring_head[e] + 1) % QueueSlots;
                        ring_count[e]--;
                    end
                    bound_used[e] = 1'b0;
                end
                push_result(ST_OK, '0, '0, 1'b1);
            end
            K_DELIVER: begin
                if (l < MinFrame) push_result(ST_TOO_SHORT, h, '0, 1'b1);
                else if (e < 0) push_result(ST_UNBOUND, h, '0, 1'b1);
                else if (ring_count[e] >= QueueSlots) push_result(ST_QUEUE_FULL, h, '0, 1'b1);
                else begin
                    s = e * QueueSlots + ring_tail[e];
                    ring_hnd[s]  = h;
                    ring_len[s]  = l;
                    ring_tail[e] = (ring_tail[e] + 1) % QueueSlots;
                    ring_count[e]++;
                    push_result(ST_OK, '0, '0, 1'b1);
                end
            end
            default: begin
                if (e < 0) push_result(ST_UNBOUND, '0, '0, 1'b1);
                else if (ring_count[e] == 0) push_result(ST_EMPTY, '0, '0, 1'b1);
                else begin
                    s = e * QueueSlots + ring_head[e];
                    push_result(ST_OK, ring_hnd[s], ring_len[s], 1'b1);
                    ring_head[e] = (ring_head[e] + 1) % QueueSlots;
                    ring_count[e]--;
                end
            end
        endcase
    endfunction

    // Sends one operation word, with a random idle gap first, and predicts it.
    task automatic send_op(t_kind kind, logic [15:0] port, logic [9:0] h = '0,
                           logic [12:0] l = '0);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        s_axis_tvalid = 1'b1;
        s_axis_tuser  = {port, kind};
        s_axis_tdata  = {1'b0, l, h};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        predict_op(kind, port, h, l);
        words_sent++;
        @(negedge i_clk);
        s_axis_tvalid = 1'b0;
    endtask

    task automatic wait_drained();
        while (pending_results.size() != 0 && !timed_out) @(negedge i_clk);
        repeat (8) @(negedge i_clk);
    endtask

    function automatic logic [12:0] rand_len();
        // Mostly valid lengths, with the threshold and the maximum visited often.
        case ($urandom_range(9))
            0: return 13'($urandom_range(41));
            1: return MinFrame;
            2: return 13'd8191;
            default: return 13'($urandom_range(4096, 42));
        endcase
    endfunction

    // Receiver: random stalls and the check of each word against the oldest prediction.
    always @(negedge i_clk) begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            words_checked++;
            if (pending_results.size() == 0) begin
                $error("unexpected result word: status %0d handle %0d", m_axis_tuser,
                       m_axis_tdata[9:0]);
                errors++;
            end else begin
                exp_r = pending_results.pop_front();
                if (m_axis_tuser != exp_r.status) begin
                    $error("status: expected %0d, got %0d", exp_r.status, m_axis_tuser);
                    errors++;
                end
                if (m_axis_tdata[9:0] != exp_r.hnd) begin
                    $error("out_handle: expected %0d, got %0d", exp_r.hnd, m_axis_tdata[9:0]);
                    errors++;
                end
                if (m_axis_tdata[22:10] != exp_r.len) begin
                    $error("out_length: expected %0d, got %0d", exp_r.len,
                           m_axis_tdata[22:10]);
                    errors++;
                end
                if (m_axis_tdata[23] != 1'b0) begin
                    $error("fill bit: expected 0, got %0b", m_axis_tdata[23]);
                    errors++;
                end
                if (m_axis_tlast != exp_r.last) begin
                    $error("last: expected %0b, got %0b", exp_r.last, m_axis_tlast);
                    errors++;
                end
            end
        end
    end

    // Watchdog: counts cycles in which no word moves on either side.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == WatchdogLimit && !timed_out) begin
            timed_out = 1'b1;
            $display("watchdog expired with %0d results outstanding",
                     pending_results.size());
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Directed: each non-full status, length threshold, duplicate bind, field extremes.
    task automatic test_directed();
        send_op(K_RECEIVE, 16'hFFFF);                 // receive on unbound port
        send_op(K_DELIVER, 16'h0000, 10'h3FF, 13'd41); // too short, beats unbound
        send_op(K_DELIVER, 16'h0000, 10'h155, 13'd42); // unbound port
        send_op(K_UNBIND, 16'h1234);                  // unbind of unbound port
        send_op(K_BIND, 16'h0000);
        send_op(K_BIND, 16'hFFFF);
        send_op(K_BIND, 16'h0000);                    // already bound
        send_op(K_RECEIVE, 16'h0000);                 // empty queue
        send_op(K_DELIVER, 16'h0000, 10'h3FF, 13'd8191);
        send_op(K_DELIVER, 16'h0000, 10'h000, 13'd42);
        send_op(K_DELIVER, 16'hFFFF, 10'h2AA, 13'h1555);
        send_op(K_RECEIVE, 16'h0000);
        send_op(K_RECEIVE, 16'hFFFF);
        send_op(K_DELIVER, 16'h0000, 10'h0, 13'd0);
        send_op(K_UNBIND, 16'h0000);                  // releases one handle
        send_op(K_UNBIND, 16'hFFFF);
    endtask

    // Fills one queue past its depth, drains it by unbind, and wraps the ring.
    task automatic test_queue_full();
        logic [15:0] port;
        port = 16'($urandom);
        send_op(K_BIND, port);
        for (int i = 0; i < QueueSlots + 2; i++)
            send_op(K_DELIVER, port, 10'($urandom), rand_len());
        for (int i = 0; i < 5; i++) send_op(K_RECEIVE, port);
        for (int i = 0; i < 6; i++) send_op(K_DELIVER, port, 10'($urandom), 13'd100);
        send_op(K_UNBIND, port);                      // up to sixteen released words
    endtask

    // Binds every entry, then one more to see table full, then frees them all.
    task automatic test_table_full();
        for (int i = 0; i < PortEntries + 1; i++) send_op(K_BIND, 16'(i * 1000 + 7));
        send_op(K_DELIVER, 16'd7, 10'd5, 13'd60);
        send_op(K_UNBIND, 16'd1007);
        send_op(K_BIND, 16'hABCD);                    // reuses the lowest free entry
        wait_drained();                               // pause until every result is in
        for (int i = 0; i < PortEntries; i++) send_op(K_UNBIND, 16'(i * 1000 + 7));
        send_op(K_UNBIND, 16'hABCD);
    endtask

    // Random operations on a small pool of ports so queues fill and drain.
    task automatic test_random(int count);
        logic [15:0] pool [6];
        logic [15:0] port;
        int          pick;
        for (int i = 0; i < 6; i++) pool[i] = 16'($urandom);
        for (int i = 0; i < count; i++) begin
            port = ($urandom_range(15) == 0) ? 16'($urandom) : pool[$urandom_range(5)];
            pick = $urandom_range(99);
            if (pick < 10) send_op(K_BIND, port);
            else if (pick < 16) send_op(K_UNBIND, port);
            else if (pick < 62) send_op(K_DELIVER, port, 10'($urandom), rand_len());
            else send_op(K_RECEIVE, port);
        end
    endtask

    initial begin
        errors         = 0;
        words_sent     = 0;
        words_checked  = 0;
        idle_cycles    = 0;
        timed_out      = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        for (int i = 0; i < PortEntries; i++) begin
            bound_used[i] = 1'b0;
            bound_port[i] = '0;
            ring_head[i]  = 0;
            ring_tail[i]  = 0;
            ring_count[i] = 0;
        end
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        m_axis_tready = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_queue_full();
        test_table_full();
        // Idling phases: none, sender idle, receiver stalling, both, then none again.
        test_random(20);
        send_idle_pct = 62;
        test_random(20);
        send_idle_pct  = 0;
        recv_stall_pct = 62;
        test_queue_full();
        test_random(20);
        send_idle_pct  = 19;
        recv_stall_pct = 19;
        test_random(20);
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        test_random(10);
        wait_drained();
        repeat (20) @(negedge i_clk);

        $display("covered %0d operation words and %0d result words", words_sent,
                 words_checked);
        $display("including table full, queue full, unbind drains and all idling phases");
        if (errors == 0 && pending_results.size() == 0) begin
            $display("CHECK OK");
        end else begin
            if (pending_results.size() != 0)
                $error("%0d expected results never arrived", pending_results.size());
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
